// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the mosaic block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/mmc_pkg.sv =====
// ---------------------------------------------------------------------------
// mmc_pkg
// Shared types, constants and helpers of the block mean color mosaic unit.
// ---------------------------------------------------------------------------
package mmc_pkg;

	localparam int CHAN_W = 8;
	localparam int CTR_W  = 6;
	localparam int CFG_W  = 7;
	localparam int CNT_W  = 13;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'hFF;
	localparam logic [CFG_W-1:0]  CFG_LIMIT = 7'd64;
	localparam logic [CFG_W-1:0]  CFG_RESET = 7'd8;

	localparam int MAX_BLOCK_COLS_DEF = 64;
	localparam int MAX_BLOCK_SIDE_DEF = 64;

	typedef enum logic [1:0] {
		REG_BLOCK_WIDTH   = 2'd0,
		REG_BLOCK_HEIGHT  = 2'd1,
		REG_BLOCKS_ACROSS = 2'd2,
		REG_BLOCKS_DOWN   = 2'd3
	} mmc_reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADD,
		S_DIV,
		S_DONE
	} mmc_state_t;

	typedef struct packed {
		logic capture;
		logic accum;
		logic div_load;
		logic div_step;
		logic out_load;
	} mmc_cmd_t;

	typedef struct packed {
		logic blk_end;
	} mmc_sts_t;

	// accumulator width for a given largest block side
	function automatic int sum_bits(input int side);
		return $clog2(side * side * 255 + 1);
	endfunction

	// 0 acts as 1, anything above top saturates
	function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
			input logic [CFG_W-1:0] top);
		logic [CFG_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = 7'd1;
		end else if (v > top) begin
			r = top;
		end
		return r;
	endfunction

endpackage

// ===== src/mmc_pix_if.sv =====
// ---------------------------------------------------------------------------
// mmc_pix_if
// Pixel channel: one RGB pixel per beat.
// ---------------------------------------------------------------------------
interface mmc_pix_if;
	logic                      valid;
	logic                      ready;
	logic [mmc_pkg::CHAN_W-1:0] pix_red;
	logic [mmc_pkg::CHAN_W-1:0] pix_green;
	logic [mmc_pkg::CHAN_W-1:0] pix_blue;

	modport source (output valid, output pix_red, output pix_green, output pix_blue,
		input ready);
	modport sink (input valid, input pix_red, input pix_green, input pix_blue,
		output ready);
endinterface

// ===== src/mmc_mean_if.sv =====
// ---------------------------------------------------------------------------
// mmc_mean_if
// Block result channel: mean color and block position per beat.
// ---------------------------------------------------------------------------
interface mmc_mean_if;
	logic                       valid;
	logic                       ready;
	logic [mmc_pkg::CHAN_W-1:0] mean_red;
	logic [mmc_pkg::CHAN_W-1:0] mean_green;
	logic [mmc_pkg::CHAN_W-1:0] mean_blue;
	logic [mmc_pkg::CTR_W-1:0]  out_block_row;
	logic [mmc_pkg::CTR_W-1:0]  out_block_col;
	logic                       frame_last;

	modport source (output valid, output mean_red, output mean_green, output mean_blue,
		output out_block_row, output out_block_col, output frame_last, input ready);
	modport sink (input valid, input mean_red, input mean_green, input mean_blue,
		input out_block_row, input out_block_col, input frame_last, output ready);
endinterface

// ===== src/mmc_div.sv =====
// ---------------------------------------------------------------------------
// mmc_div
// Restoring divider lane, one quotient bit per step, mean saturated to 8 bits.
// ---------------------------------------------------------------------------
module mmc_div #(
	parameter int NUM_W = 20
) (
	input  logic                       clk,
	input  logic                       ld,
	input  logic                       step,
	input  logic [NUM_W-1:0]           num,
	input  logic [mmc_pkg::CNT_W-1:0]  den,
	output logic [mmc_pkg::CHAN_W-1:0] mean
);
	localparam int CW = mmc_pkg::CNT_W;

	logic [NUM_W-1:0] quo_q;
	logic [CW-1:0]    rem_q;
	logic [CW-1:0]    den_q;
	logic [CW:0]      rem_sh;
	logic [CW+1:0]    diff;

	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den_q};

	always_ff @(posedge clk) begin
		if (ld) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (step) begin
			if (!diff[CW+1]) begin
				rem_q <= diff[CW-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[CW-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign mean = (quo_q > NUM_W'(mmc_pkg::CHAN_MAX)) ? mmc_pkg::CHAN_MAX
		: quo_q[mmc_pkg::CHAN_W-1:0];
endmodule

// ===== src/mmc_datapath.sv =====
// ---------------------------------------------------------------------------
// mmc_datapath
// Position counters, per-column sum memory, divider lanes and result register.
// ---------------------------------------------------------------------------
module mmc_datapath #(
	parameter int MAX_BLOCK_COLS = mmc_pkg::MAX_BLOCK_COLS_DEF,
	parameter int MAX_BLOCK_SIDE = mmc_pkg::MAX_BLOCK_SIDE_DEF,
	parameter int SUM_W          = mmc_pkg::sum_bits(mmc_pkg::MAX_BLOCK_SIDE_DEF)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mmc_pkg::mmc_cmd_t          cmd,
	output mmc_pkg::mmc_sts_t          sts,
	input  logic [mmc_pkg::CFG_W-1:0]  block_width,
	input  logic [mmc_pkg::CFG_W-1:0]  block_height,
	input  logic [mmc_pkg::CFG_W-1:0]  blocks_across,
	input  logic [mmc_pkg::CFG_W-1:0]  blocks_down,
	input  logic [mmc_pkg::CHAN_W-1:0] pix_red,
	input  logic [mmc_pkg::CHAN_W-1:0] pix_green,
	input  logic [mmc_pkg::CHAN_W-1:0] pix_blue,
	output logic [mmc_pkg::CHAN_W-1:0] mean_red,
	output logic [mmc_pkg::CHAN_W-1:0] mean_green,
	output logic [mmc_pkg::CHAN_W-1:0] mean_blue,
	output logic [mmc_pkg::CTR_W-1:0]  out_block_row,
	output logic [mmc_pkg::CTR_W-1:0]  out_block_col,
	output logic                       frame_last
);
	localparam int COL_AW = (MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1;
	localparam logic [SUM_W-1:0] SUM_LIMIT = SUM_W'(MAX_BLOCK_SIDE * MAX_BLOCK_SIDE * 255);
	localparam logic [mmc_pkg::CFG_W-1:0] SIDE_TOP = (MAX_BLOCK_SIDE < 64)
		? mmc_pkg::CFG_W'(MAX_BLOCK_SIDE) : mmc_pkg::CFG_LIMIT;
	localparam logic [mmc_pkg::CFG_W-1:0] COL_TOP = (MAX_BLOCK_COLS < 64)
		? mmc_pkg::CFG_W'(MAX_BLOCK_COLS) : mmc_pkg::CFG_LIMIT;
	localparam int CW  = mmc_pkg::CTR_W;
	localparam int FW  = mmc_pkg::CFG_W;
	localparam int CHW = mmc_pkg::CHAN_W;

	logic [FW-1:0] bw, bh, ba, bd;
	logic          x_end, y_end, c_end, r_end;
	logic [8:0]    col_ext, col_cap;
	logic [COL_AW-1:0] addr;

	logic [CW-1:0] x_q, y_q, col_q, row_q;

	logic [2:0][SUM_W-1:0] mem [MAX_BLOCK_COLS];
	logic [MAX_BLOCK_COLS-1:0] vld_q;

	logic [2:0][CHW-1:0]   px_s1;
	logic [2:0][SUM_W-1:0] rd_s1;
	logic                  vld_s1;
	logic [COL_AW-1:0]     addr_s1;
	logic                  blk_end_s1;
	logic                  row_clr_s1;
	logic [CW-1:0]         row_s1, col_s1;
	logic                  last_s1;
	logic [mmc_pkg::CNT_W-1:0] cnt_s1;
	logic [2*FW-1:0]       cnt_full;

	logic [2:0][SUM_W:0]   sum_wide;
	logic [2:0][SUM_W-1:0] sum_new;
	logic [2:0][CHW-1:0]   lane_mean;

	logic [2:0][CHW-1:0]   mean_q;
	logic [CW-1:0]         row_q_out, col_q_out;
	logic                  last_q;

	assign bw = mmc_pkg::clamp_cfg(block_width, SIDE_TOP);
	assign bh = mmc_pkg::clamp_cfg(block_height, SIDE_TOP);
	assign ba = mmc_pkg::clamp_cfg(blocks_across, COL_TOP);
	assign bd = mmc_pkg::clamp_cfg(blocks_down, mmc_pkg::CFG_LIMIT);

	assign x_end = ({1'b0, x_q} + 7'd1) >= bw;
	assign y_end = ({1'b0, y_q} + 7'd1) >= bh;
	assign c_end = ({1'b0, col_q} + 7'd1) >= ba;
	assign r_end = ({1'b0, row_q} + 7'd1) >= bd;

	assign col_ext  = 9'(col_q);
	assign col_cap  = (col_ext >= 9'(MAX_BLOCK_COLS)) ? 9'(MAX_BLOCK_COLS - 1) : col_ext;
	assign addr     = col_cap[COL_AW-1:0];
	assign cnt_full = bw * bh;

	// raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q        <= '0;
			y_q        <= '0;
			col_q      <= '0;
			row_q      <= '0;
			blk_end_s1 <= 1'b0;
			row_clr_s1 <= 1'b0;
		end else if (cmd.capture) begin
			blk_end_s1 <= x_end && y_end;
			row_clr_s1 <= x_end && c_end && y_end;
			if (!x_end) begin
				x_q <= x_q + 1'b1;
			end else begin
				x_q <= '0;
				if (!c_end) begin
					col_q <= col_q + 1'b1;
				end else begin
					col_q <= '0;
					if (!y_end) begin
						y_q <= y_q + 1'b1;
					end else begin
						y_q   <= '0;
						row_q <= r_end ? '0 : row_q + 1'b1;
					end
				end
			end
		end
	end

	// column valid bits; an invalid column reads as a zero sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.accum) begin
			if (row_clr_s1) begin
				vld_q <= '0;
			end else begin
				vld_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_s1 <= mem[addr];
		end
		if (cmd.accum) begin
			mem[addr_s1] <= sum_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			px_s1   <= {pix_red, pix_green, pix_blue};
			vld_s1  <= vld_q[addr];
			addr_s1 <= addr;
			row_s1  <= row_q;
			col_s1  <= col_q;
			last_s1 <= c_end && r_end;
			cnt_s1  <= cnt_full[mmc_pkg::CNT_W-1:0];
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_wide[c] = (vld_s1 ? {1'b0, rd_s1[c]} : '0) + (SUM_W + 1)'(px_s1[c]);
			sum_new[c]  = (sum_wide[c] > {1'b0, SUM_LIMIT}) ? SUM_LIMIT
				: sum_wide[c][SUM_W-1:0];
		end
	end

	mmc_div #(.NUM_W(SUM_W)) u_div_red (
		.clk  (clk),
		.ld   (cmd.div_load),
		.step (cmd.div_step),
		.num  (sum_new[2]),
		.den  (cnt_s1),
		.mean (lane_mean[2])
	);

	mmc_div #(.NUM_W(SUM_W)) u_div_green (
		.clk  (clk),
		.ld   (cmd.div_load),
		.step (cmd.div_step),
		.num  (sum_new[1]),
		.den  (cnt_s1),
		.mean (lane_mean[1])
	);

	mmc_div #(.NUM_W(SUM_W)) u_div_blue (
		.clk  (clk),
		.ld   (cmd.div_load),
		.step (cmd.div_step),
		.num  (sum_new[0]),
		.den  (cnt_s1),
		.mean (lane_mean[0])
	);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mean_q    <= lane_mean;
			row_q_out <= row_s1;
			col_q_out <= col_s1;
			last_q    <= last_s1;
		end
	end

	assign sts.blk_end   = blk_end_s1;
	assign mean_red      = mean_q[2];
	assign mean_green    = mean_q[1];
	assign mean_blue     = mean_q[0];
	assign out_block_row = row_q_out;
	assign out_block_col = col_q_out;
	assign frame_last    = last_q;
endmodule

// ===== src/mmc_ctrl.sv =====
// ---------------------------------------------------------------------------
// mmc_ctrl
// Sequencer: pixel capture, accumulate, divide, result hand-off.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mmc_ctrl #(
	parameter int DIV_STEPS = mmc_pkg::sum_bits(mmc_pkg::MAX_BLOCK_SIDE_DEF)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  mmc_pkg::mmc_sts_t sts,
	output mmc_pkg::mmc_cmd_t cmd
);
	localparam int SCW = $clog2(DIV_STEPS + 1);

	mmc_pkg::mmc_state_t state_q, state_nx;
	logic [SCW-1:0]      step_cnt_q;
	logic                out_vld_q;
	logic                slot_free;

	assign slot_free = !out_vld_q || out_ready;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			mmc_pkg::S_IDLE: begin
				if (in_valid) begin
					state_nx = mmc_pkg::S_ADD;
				end
			end
			mmc_pkg::S_ADD: begin
				state_nx = sts.blk_end ? mmc_pkg::S_DIV : mmc_pkg::S_IDLE;
			end
			mmc_pkg::S_DIV: begin
				if (step_cnt_q == SCW'(DIV_STEPS - 1)) begin
					state_nx = mmc_pkg::S_DONE;
				end
			end
			mmc_pkg::S_DONE: begin
				if (slot_free) begin
					state_nx = mmc_pkg::S_IDLE;
				end
			end
			default: state_nx = mmc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			mmc_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			mmc_pkg::S_ADD: begin
				cmd.accum    = 1'b1;
				cmd.div_load = sts.blk_end;
			end
			mmc_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
			end
			mmc_pkg::S_DONE: begin
				cmd.out_load = slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mmc_pkg::S_IDLE;
			step_cnt_q <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.div_load) begin
				step_cnt_q <= '0;
			end else if (cmd.div_step) begin
				step_cnt_q <= step_cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_vld_q;

	`ASSERT_IMPL(a_no_overwrite, clk, arst_n, cmd.out_load, !out_vld_q || out_ready, "pending result overwritten")
	`ASSERT_NEXT(a_cap_to_add, clk, arst_n, cmd.capture, state_q == mmc_pkg::S_ADD, "capture not followed by accumulate")
	`ASSERT_NEXT(a_blk_to_div, clk, arst_n, state_q == mmc_pkg::S_ADD && sts.blk_end, state_q == mmc_pkg::S_DIV, "block end did not start divide")
	`ASSERT_IMPL(a_full_div, clk, arst_n, state_q == mmc_pkg::S_DONE && $past(state_q) == mmc_pkg::S_DIV, $past(step_cnt_q) == SCW'(DIV_STEPS - 1), "divide cut short")
endmodule

// ===== src/block_mean_color_mosaic_unit.sv =====
// ---------------------------------------------------------------------------
// block_mean_color_mosaic_unit
// Block-average mosaic: per-block mean RGB of a raster pixel stream.
// ---------------------------------------------------------------------------
// Throughput: each pixel is captured, then accumulated before the next is taken;
//   a pixel that closes a block holds the input through the bit-serial divide.
// Result: registered after the divide that follows the block's last pixel beat.
// A waiting result does not stall pixel intake until the next block result.
// Reset: registers return to 8, position counters and column valid bits to zero.
module block_mean_color_mosaic_unit #(
	parameter int MAX_BLOCK_COLS = mmc_pkg::MAX_BLOCK_COLS_DEF,
	parameter int MAX_BLOCK_SIDE = mmc_pkg::MAX_BLOCK_SIDE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	mmc_pix_if.sink                     pixel,
	mmc_mean_if.source                  block,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mmc_pkg::ADDR_W-1:0]  paddr,
	input  logic [mmc_pkg::DATA_W-1:0]  pwdata,
	output logic [mmc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	localparam int SUM_W = mmc_pkg::sum_bits(MAX_BLOCK_SIDE);
	localparam int FW    = mmc_pkg::CFG_W;

	logic [FW-1:0] block_width_q, block_height_q, blocks_across_q, blocks_down_q;
	logic          wr_en;
	mmc_pkg::mmc_reg_t reg_sel;
	mmc_pkg::mmc_cmd_t cmd;
	mmc_pkg::mmc_sts_t sts;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = mmc_pkg::mmc_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_width_q   <= mmc_pkg::CFG_RESET;
			block_height_q  <= mmc_pkg::CFG_RESET;
			blocks_across_q <= mmc_pkg::CFG_RESET;
			blocks_down_q   <= mmc_pkg::CFG_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				mmc_pkg::REG_BLOCK_WIDTH:   block_width_q   <= pwdata[FW-1:0];
				mmc_pkg::REG_BLOCK_HEIGHT:  block_height_q  <= pwdata[FW-1:0];
				mmc_pkg::REG_BLOCKS_ACROSS: blocks_across_q <= pwdata[FW-1:0];
				mmc_pkg::REG_BLOCKS_DOWN:   blocks_down_q   <= pwdata[FW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			mmc_pkg::REG_BLOCK_WIDTH:   prdata = mmc_pkg::DATA_W'(block_width_q);
			mmc_pkg::REG_BLOCK_HEIGHT:  prdata = mmc_pkg::DATA_W'(block_height_q);
			mmc_pkg::REG_BLOCKS_ACROSS: prdata = mmc_pkg::DATA_W'(blocks_across_q);
			mmc_pkg::REG_BLOCKS_DOWN:   prdata = mmc_pkg::DATA_W'(blocks_down_q);
			default:                    prdata = '0;
		endcase
	end

	mmc_ctrl #(.DIV_STEPS(SUM_W)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_ready  (pixel.ready),
		.out_valid (block.valid),
		.out_ready (block.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mmc_datapath #(
		.MAX_BLOCK_COLS (MAX_BLOCK_COLS),
		.MAX_BLOCK_SIDE (MAX_BLOCK_SIDE),
		.SUM_W          (SUM_W)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.block_width   (block_width_q),
		.block_height  (block_height_q),
		.blocks_across (blocks_across_q),
		.blocks_down   (blocks_down_q),
		.pix_red       (pixel.pix_red),
		.pix_green     (pixel.pix_green),
		.pix_blue      (pixel.pix_blue),
		.mean_red      (block.mean_red),
		.mean_green    (block.mean_green),
		.mean_blue     (block.mean_blue),
		.out_block_row (block.out_block_row),
		.out_block_col (block.out_block_col),
		.frame_last    (block.frame_last)
	);
endmodule

// ===== tb/block_mean_color_mosaic_unit_test.sv =====
// ---------------------------------------------------------------------------
// block_mean_color_mosaic_unit_test
// Self-checking bench for the block mean color mosaic unit. A raster pixel
// stream is driven in random bursts while the result side stalls on its own
// pattern. A behavioral model of the block sums and counters predicts every
// block mean, and each result beat is compared field by field. Registers are
// set over APB between phases and read back.
// ---------------------------------------------------------------------------
module block_mean_color_mosaic_unit_test;

	localparam int unsigned SETTING_CAP = 64;
	localparam int unsigned ACC_COLS    = mmc_pkg::MAX_BLOCK_COLS_DEF;
	localparam int unsigned CHAN_TOP    = (1 << mmc_pkg::CHAN_W) - 1;
	localparam int unsigned SUM_CAP     = mmc_pkg::MAX_BLOCK_SIDE_DEF
		* mmc_pkg::MAX_BLOCK_SIDE_DEF * CHAN_TOP;
	localparam int          SETTLE_CYCLES  = 64;
	localparam int          WATCHDOG_LIMIT = 4000;
	localparam int          RX_HOLD_CYCLES = 400;
	localparam int          RANDOM_ITEMS   = 1150;
	localparam int          WIDE_ROWS      = 4;

	typedef struct packed {
		logic [mmc_pkg::CHAN_W-1:0] red;
		logic [mmc_pkg::CHAN_W-1:0] green;
		logic [mmc_pkg::CHAN_W-1:0] blue;
	} pix_t;

	typedef struct packed {
		logic [mmc_pkg::CHAN_W-1:0] red;
		logic [mmc_pkg::CHAN_W-1:0] green;
		logic [mmc_pkg::CHAN_W-1:0] blue;
		logic [mmc_pkg::CTR_W-1:0]  row;
		logic [mmc_pkg::CTR_W-1:0]  col;
		logic                       last;
	} block_mean_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [mmc_pkg::ADDR_W-1:0] paddr = '0;
	logic [mmc_pkg::DATA_W-1:0] pwdata = '0;
	logic [mmc_pkg::DATA_W-1:0] prdata;
	logic pready;

	mmc_pix_if  pixel_ch ();
	mmc_mean_if mean_ch ();

	block_mean_color_mosaic_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel   (pixel_ch),
		.block   (mean_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #1 clk = ~clk;

	// block model state
	logic [mmc_pkg::CFG_W-1:0] set_width, set_height, set_across, set_down;
	int unsigned red_acc [ACC_COLS];
	int unsigned green_acc [ACC_COLS];
	int unsigned blue_acc [ACC_COLS];
	int unsigned px_x, px_y, blk_col, blk_row;

	block_mean_t means_due [$];
	int failures = 0;
	int idle_cycles = 0;
	int items_sent = 0;
	int burst_left = 0;
	bit tx_gaps = 1'b1;
	bit rx_stalls = 1'b1;
	bit rx_hold_req = 1'b0;

	function automatic int unsigned bounded(input logic [mmc_pkg::CFG_W-1:0] v);
		if (v == '0) begin
			return 1;
		end
		return (v > SETTING_CAP) ? SETTING_CAP : v;
	endfunction

	function automatic int unsigned add_capped(input int unsigned sum,
			input logic [mmc_pkg::CHAN_W-1:0] v);
		int unsigned s;
		s = sum + v;
		return (s > SUM_CAP) ? SUM_CAP : s;
	endfunction

	function automatic logic [mmc_pkg::CHAN_W-1:0] block_mean(input int unsigned sum,
			input int unsigned n);
		int unsigned q;
		q = sum / n;
		return (q > CHAN_TOP) ? CHAN_TOP[mmc_pkg::CHAN_W-1:0] : q[mmc_pkg::CHAN_W-1:0];
	endfunction

	function automatic void clear_sums();
		for (int i = 0; i < ACC_COLS; i++) begin
			red_acc[i] = 0;
			green_acc[i] = 0;
			blue_acc[i] = 0;
		end
	endfunction

	function automatic void accumulate_pixel(input pix_t p);
		int unsigned bw, bh, ba, bd, col;
		logic x_end, y_end, c_end, r_end;
		block_mean_t m;
		bw = bounded(set_width);
		bh = bounded(set_height);
		ba = bounded(set_across);
		bd = bounded(set_down);
		col = (blk_col < ACC_COLS) ? blk_col : ACC_COLS - 1;
		x_end = (px_x + 1 >= bw);
		y_end = (px_y + 1 >= bh);
		c_end = (blk_col + 1 >= ba);
		r_end = (blk_row + 1 >= bd);
		red_acc[col] = add_capped(red_acc[col], p.red);
		green_acc[col] = add_capped(green_acc[col], p.green);
		blue_acc[col] = add_capped(blue_acc[col], p.blue);
		if (x_end && y_end) begin
			m.red = block_mean(red_acc[col], bw * bh);
			m.green = block_mean(green_acc[col], bw * bh);
			m.blue = block_mean(blue_acc[col], bw * bh);
			m.row = blk_row[mmc_pkg::CTR_W-1:0];
			m.col = blk_col[mmc_pkg::CTR_W-1:0];
			m.last = c_end && r_end;
			means_due.push_back(m);
		end
		if (!x_end) begin
			px_x++;
		end else begin
			px_x = 0;
			if (!c_end) begin
				blk_col++;
			end else begin
				blk_col = 0;
				if (!y_end) begin
					px_y++;
				end else begin
					px_y = 0;
					clear_sums();
					blk_row = r_end ? 0 : blk_row + 1;
				end
			end
		end
	endfunction

	task automatic compare_field(input string name, input logic [mmc_pkg::CHAN_W-1:0] want,
			input logic [mmc_pkg::CHAN_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
			failures++;
		end
	endtask

	// result checking, model update on every pixel beat, idle count for the watchdog
	always @(posedge clk) begin : beat_monitor
		block_mean_t want;
		logic moved;
		moved = 1'b0;
		if (mean_ch.valid === 1'b1 && mean_ch.ready === 1'b1) begin
			moved = 1'b1;
			if (means_due.size() == 0) begin
				$display("%0t: unexpected block result: row %0d col %0d", $time,
					mean_ch.out_block_row, mean_ch.out_block_col);
				failures++;
			end else begin
				want = means_due.pop_front();
				compare_field("mean_red", want.red, mean_ch.mean_red);
				compare_field("mean_green", want.green, mean_ch.mean_green);
				compare_field("mean_blue", want.blue, mean_ch.mean_blue);
				compare_field("out_block_row", want.row, mean_ch.out_block_row);
				compare_field("out_block_col", want.col, mean_ch.out_block_col);
				compare_field("frame_last", want.last, mean_ch.frame_last);
			end
		end
		if (pixel_ch.valid === 1'b1 && pixel_ch.ready === 1'b1) begin
			moved = 1'b1;
			accumulate_pixel({pixel_ch.pix_red, pixel_ch.pix_green, pixel_ch.pix_blue});
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
	end

	initial begin : watchdog
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
		end
		$display("Test completed with failures");
		$finish;
	end

	// result side: random stalls, or a long hold-off on request
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		mean_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				mean_ch.ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold_req = 1'b0;
			end else if (!rx_stalls) begin
				mean_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				mean_ch.ready <= 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 3) == 0) begin
				mean_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 20);
			end else begin
				mean_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_pixel(input pix_t p);
		int gap;
		if (tx_gaps && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(1, 10);
			pixel_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		pixel_ch.valid <= 1'b1;
		pixel_ch.pix_red <= p.red;
		pixel_ch.pix_green <= p.green;
		pixel_ch.pix_blue <= p.blue;
		do @(posedge clk); while (pixel_ch.ready !== 1'b1);
		items_sent++;
	endtask

	task automatic wait_for_means();
		pixel_ch.valid <= 1'b0;
		do @(posedge clk); while (means_due.size() != 0);
	endtask

	task automatic idle_for_config();
		wait_for_means();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_setting(input mmc_pkg::mmc_reg_t idx,
			input logic [mmc_pkg::CFG_W-1:0] v);
		logic [mmc_pkg::DATA_W-1:0] word;
		word = $urandom();
		word[mmc_pkg::CFG_W-1:0] = v;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			mmc_pkg::REG_BLOCK_WIDTH: set_width = v;
			mmc_pkg::REG_BLOCK_HEIGHT: set_height = v;
			mmc_pkg::REG_BLOCKS_ACROSS: set_across = v;
			mmc_pkg::REG_BLOCKS_DOWN: set_down = v;
			default: ;
		endcase
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {{(mmc_pkg::DATA_W-mmc_pkg::CFG_W){1'b0}}, v}) begin
			$display("%0t: register %s read back: expected %0d, got %0d", $time,
				idx.name(), v, prdata);
			failures++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_grid(input logic [mmc_pkg::CFG_W-1:0] bw,
			input logic [mmc_pkg::CFG_W-1:0] bh,
			input logic [mmc_pkg::CFG_W-1:0] ba, input logic [mmc_pkg::CFG_W-1:0] bd);
		write_setting(mmc_pkg::REG_BLOCK_WIDTH, bw);
		write_setting(mmc_pkg::REG_BLOCK_HEIGHT, bh);
		write_setting(mmc_pkg::REG_BLOCKS_ACROSS, ba);
		write_setting(mmc_pkg::REG_BLOCKS_DOWN, bd);
	endtask

	function automatic logic [mmc_pkg::CHAN_W-1:0] random_channel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return CHAN_TOP[mmc_pkg::CHAN_W-1:0];
			default: return mmc_pkg::CHAN_W'($urandom_range(0, CHAN_TOP));
		endcase
	endfunction

	function automatic pix_t random_pixel();
		pix_t p;
		p.red = random_channel();
		p.green = random_channel();
		p.blue = random_channel();
		return p;
	endfunction

	function automatic logic [mmc_pkg::CFG_W-1:0] pick_setting(input int unsigned hi);
		case ($urandom_range(0, 15))
			0: return '0;
			1: return mmc_pkg::CFG_W'($urandom_range(SETTING_CAP + 1,
				(1 << mmc_pkg::CFG_W) - 1));
			2: return mmc_pkg::CFG_W'(SETTING_CAP);
			default: return mmc_pkg::CFG_W'($urandom_range(1, hi));
		endcase
	endfunction

	// 1x1 grid for one pixel: every counter wraps to zero
	task automatic realign_frame();
		idle_for_config();
		write_grid('0, '0, '0, '0);
		send_pixel(random_pixel());
		idle_for_config();
	endtask

	// all-black, all-white, alternating-bit and mixed blocks on a 2x2 grid of 2x2 blocks
	task automatic test_channel_extremes();
		logic [23:0] pats [16] = '{
			24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF,
			24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF,
			24'hAA55AA, 24'h55AA55, 24'h01807F, 24'hFE7F80,
			24'hAA55AA, 24'h55AA55, 24'h00FF00, 24'hFF00FF};
		idle_for_config();
		write_grid(7'd2, 7'd2, 7'd2, 7'd2);
		foreach (pats[i]) begin
			send_pixel(pats[i]);
		end
	endtask

	// shrink the block mid-block: counters past the new end close it at once,
	// and the mean of four pixels over one saturates
	task automatic test_midframe_resize();
		idle_for_config();
		write_grid(7'd2, 7'd2, 7'd1, 7'd2);
		send_pixel(24'h90C864);
		send_pixel(24'h6490C8);
		send_pixel(24'hC86490);
		idle_for_config();
		write_setting(mmc_pkg::REG_BLOCK_WIDTH, 7'd1);
		write_setting(mmc_pkg::REG_BLOCK_HEIGHT, 7'd1);
		send_pixel(24'h807F01);
	endtask

	// zero in every register acts as one
	task automatic test_setting_clamp();
		idle_for_config();
		write_grid('0, '0, '0, '0);
		repeat (3) send_pixel(random_pixel());
	endtask

	// result side holds off while pixels keep coming, then the source waits it out
	task automatic test_output_backpressure();
		idle_for_config();
		write_grid(7'd1, 7'd1, 7'd3, 7'd2);
		tx_gaps = 1'b0;
		rx_hold_req = 1'b1;
		repeat (30) send_pixel(random_pixel());
		wait_for_means();
		repeat (20) send_pixel(random_pixel());
		tx_gaps = 1'b1;
	endtask

	task automatic test_random_frames();
		int start, n, pause_at;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			idle_for_config();
			if ($urandom_range(0, 3) != 0)
				write_setting(mmc_pkg::REG_BLOCK_WIDTH, pick_setting(4));
			if ($urandom_range(0, 3) != 0)
				write_setting(mmc_pkg::REG_BLOCK_HEIGHT, pick_setting(4));
			if ($urandom_range(0, 3) != 0)
				write_setting(mmc_pkg::REG_BLOCKS_ACROSS, pick_setting(8));
			if ($urandom_range(0, 3) != 0)
				write_setting(mmc_pkg::REG_BLOCKS_DOWN, pick_setting(6));
			tx_gaps = ($urandom_range(0, 3) != 0);
			rx_stalls = ($urandom_range(0, 3) != 0);
			n = $urandom_range(10, 150);
			pause_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n - 1) : -1;
			for (int i = 0; i < n; i++) begin
				if (i == pause_at) begin
					wait_for_means();
				end
				send_pixel(random_pixel());
			end
		end
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
	endtask

	// widest and tallest white blocks, side registers above range saturate
	task automatic test_largest_block();
		realign_frame();
		write_grid(7'd127, 7'(WIDE_ROWS), 7'd1, 7'd1);
		repeat (SETTING_CAP * WIDE_ROWS) send_pixel(24'hFFFFFF);
		idle_for_config();
		write_grid(7'd1, 7'd127, 7'd1, 7'd1);
		repeat (SETTING_CAP) send_pixel(24'hFFFFFF);
	endtask

	// one-pixel blocks: a full row of block columns, then a full column of block rows
	task automatic test_full_grid();
		realign_frame();
		write_grid(7'd1, 7'd1, 7'd100, 7'd1);
		repeat (SETTING_CAP) send_pixel(random_pixel());
		idle_for_config();
		write_grid(7'd1, 7'd1, 7'd1, 7'd127);
		repeat (SETTING_CAP) send_pixel(random_pixel());
	endtask

	initial begin
		pixel_ch.valid <= 1'b0;
		pixel_ch.pix_red <= '0;
		pixel_ch.pix_green <= '0;
		pixel_ch.pix_blue <= '0;
		set_width = mmc_pkg::CFG_RESET;
		set_height = mmc_pkg::CFG_RESET;
		set_across = mmc_pkg::CFG_RESET;
		set_down = mmc_pkg::CFG_RESET;
		clear_sums();
		px_x = 0;
		px_y = 0;
		blk_col = 0;
		blk_row = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_channel_extremes();
		test_midframe_resize();
		test_setting_clamp();
		test_output_backpressure();
		test_random_frames();
		test_largest_block();
		test_full_grid();

		idle_for_config();
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
